/* hw/rtl/srect_pkg.sv */
// ---------------------------------------------------------------------------
// srect_pkg: shared types and constants for the segment/rectangle hit test
// Corner numbering and the flag group that the preparation stage hands on
// to the decision stage.
// ---------------------------------------------------------------------------
package srect_pkg;

  // Corner numbering of the sorted rectangle
  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned CORNER_TL   = 0;  // (x_lo, y_hi)
  localparam int unsigned CORNER_TR   = 1;  // (x_hi, y_hi)
  localparam int unsigned CORNER_BL   = 2;  // (x_lo, y_lo)
  localparam int unsigned CORNER_BR   = 3;  // (x_hi, y_lo)

  // Edge numbering
  localparam int unsigned NUM_EDGES   = 4;
  localparam int unsigned EDGE_TOP    = 0;  // TL - TR
  localparam int unsigned EDGE_LEFT   = 1;  // TL - BL
  localparam int unsigned EDGE_BOTTOM = 2;  // BR - BL
  localparam int unsigned EDGE_RIGHT  = 3;  // BR - TR

  // Comparison results that need no multiplication
  typedef struct packed {
    logic                   point_inside;   // an endpoint lies in the closed box
    logic [NUM_CORNERS-1:0] corner_in_box;  // corner within the segment's bounding box
    logic [NUM_EDGES-1:0]   edge_straddle;  // segment ends strictly either side of edge
  } srect_flags_t;

endpackage

/* hw/rtl/srect_prep.sv */
// ---------------------------------------------------------------------------
// srect_prep: corner sort, coordinate differences and comparison flags
// Orders the rectangle corners, forms the segment direction and the corner
// offsets from the segment start, and evaluates every test that needs only
// comparisons.
// ---------------------------------------------------------------------------
module srect_prep #(
  parameter int COORD_WIDTH = 16
) (
  input  logic signed [COORD_WIDTH-1:0] corner_one_x,
  input  logic signed [COORD_WIDTH-1:0] corner_one_y,
  input  logic signed [COORD_WIDTH-1:0] corner_two_x,
  input  logic signed [COORD_WIDTH-1:0] corner_two_y,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y,
  output logic signed [COORD_WIDTH:0]   dir_x,
  output logic signed [COORD_WIDTH:0]   dir_y,
  output logic signed [COORD_WIDTH:0]   off_x_lo,
  output logic signed [COORD_WIDTH:0]   off_x_hi,
  output logic signed [COORD_WIDTH:0]   off_y_lo,
  output logic signed [COORD_WIDTH:0]   off_y_hi,
  output srect_pkg::srect_flags_t       flags
);

  logic signed [COORD_WIDTH-1:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [COORD_WIDTH-1:0] sx_lo, sx_hi, sy_lo, sy_hi;
  logic                          wide, tall;
  logic                          start_in, end_in;
  logic signed [COORD_WIDTH-1:0] cx [srect_pkg::NUM_CORNERS];
  logic signed [COORD_WIDTH-1:0] cy [srect_pkg::NUM_CORNERS];

  // Sort the rectangle corners
  always_comb begin
    x_lo = (corner_one_x < corner_two_x) ? corner_one_x : corner_two_x;
    x_hi = (corner_one_x < corner_two_x) ? corner_two_x : corner_one_x;
    y_lo = (corner_one_y < corner_two_y) ? corner_one_y : corner_two_y;
    y_hi = (corner_one_y < corner_two_y) ? corner_two_y : corner_one_y;
    wide = x_hi > x_lo;
    tall = y_hi > y_lo;
  end

  // Bounding box of the segment
  always_comb begin
    sx_lo = (seg_start_x < seg_end_x) ? seg_start_x : seg_end_x;
    sx_hi = (seg_start_x < seg_end_x) ? seg_end_x : seg_start_x;
    sy_lo = (seg_start_y < seg_end_y) ? seg_start_y : seg_end_y;
    sy_hi = (seg_start_y < seg_end_y) ? seg_end_y : seg_start_y;
  end

  // Corner positions in fixed order
  always_comb begin
    cx[srect_pkg::CORNER_TL] = x_lo;
    cy[srect_pkg::CORNER_TL] = y_hi;
    cx[srect_pkg::CORNER_TR] = x_hi;
    cy[srect_pkg::CORNER_TR] = y_hi;
    cx[srect_pkg::CORNER_BL] = x_lo;
    cy[srect_pkg::CORNER_BL] = y_lo;
    cx[srect_pkg::CORNER_BR] = x_hi;
    cy[srect_pkg::CORNER_BR] = y_lo;
  end

  // Differences, one bit wider than the coordinates
  always_comb begin
    dir_x    = $signed({seg_end_x[COORD_WIDTH-1], seg_end_x})
             - $signed({seg_start_x[COORD_WIDTH-1], seg_start_x});
    dir_y    = $signed({seg_end_y[COORD_WIDTH-1], seg_end_y})
             - $signed({seg_start_y[COORD_WIDTH-1], seg_start_y});
    off_x_lo = $signed({x_lo[COORD_WIDTH-1], x_lo})
             - $signed({seg_start_x[COORD_WIDTH-1], seg_start_x});
    off_x_hi = $signed({x_hi[COORD_WIDTH-1], x_hi})
             - $signed({seg_start_x[COORD_WIDTH-1], seg_start_x});
    off_y_lo = $signed({y_lo[COORD_WIDTH-1], y_lo})
             - $signed({seg_start_y[COORD_WIDTH-1], seg_start_y});
    off_y_hi = $signed({y_hi[COORD_WIDTH-1], y_hi})
             - $signed({seg_start_y[COORD_WIDTH-1], seg_start_y});
  end

  // Comparison flags
  always_comb begin
    // Endpoints inside the closed rectangle
    start_in = (seg_start_x >= x_lo) && (seg_start_x <= x_hi)
            && (seg_start_y >= y_lo) && (seg_start_y <= y_hi);
    end_in   = (seg_end_x >= x_lo) && (seg_end_x <= x_hi)
            && (seg_end_y >= y_lo) && (seg_end_y <= y_hi);
    flags.point_inside = start_in || end_in;

    // Corner within the segment's bounding box; with a zero cross product
    // this places the corner on the segment
    for (int c = 0; c < srect_pkg::NUM_CORNERS; c++) begin
      flags.corner_in_box[c] = (cx[c] >= sx_lo) && (cx[c] <= sx_hi)
                            && (cy[c] >= sy_lo) && (cy[c] <= sy_hi);
    end

    // Segment ends strictly on opposite sides of each non-degenerate edge
    flags.edge_straddle[srect_pkg::EDGE_TOP] = wide &&
      (((seg_start_y > y_hi) && (seg_end_y < y_hi)) ||
       ((seg_start_y < y_hi) && (seg_end_y > y_hi)));
    flags.edge_straddle[srect_pkg::EDGE_BOTTOM] = wide &&
      (((seg_start_y > y_lo) && (seg_end_y < y_lo)) ||
       ((seg_start_y < y_lo) && (seg_end_y > y_lo)));
    flags.edge_straddle[srect_pkg::EDGE_LEFT] = tall &&
      (((seg_start_x > x_lo) && (seg_end_x < x_lo)) ||
       ((seg_start_x < x_lo) && (seg_end_x > x_lo)));
    flags.edge_straddle[srect_pkg::EDGE_RIGHT] = tall &&
      (((seg_start_x > x_hi) && (seg_end_x < x_hi)) ||
       ((seg_start_x < x_hi) && (seg_end_x > x_hi)));
  end

endmodule

/* hw/rtl/srect_mul.sv */
// ---------------------------------------------------------------------------
// srect_mul: cross-product terms
// Forms the four exact products from which the cross product of the
// segment direction with each corner offset is built.
// ---------------------------------------------------------------------------
module srect_mul #(
  parameter int COORD_WIDTH = 16
) (
  input  logic signed [COORD_WIDTH:0]     dir_x,
  input  logic signed [COORD_WIDTH:0]     dir_y,
  input  logic signed [COORD_WIDTH:0]     off_x_lo,
  input  logic signed [COORD_WIDTH:0]     off_x_hi,
  input  logic signed [COORD_WIDTH:0]     off_y_lo,
  input  logic signed [COORD_WIDTH:0]     off_y_hi,
  output logic signed [2*COORD_WIDTH+1:0] prod_dx_ylo,
  output logic signed [2*COORD_WIDTH+1:0] prod_dx_yhi,
  output logic signed [2*COORD_WIDTH+1:0] prod_dy_xlo,
  output logic signed [2*COORD_WIDTH+1:0] prod_dy_xhi
);

  // Full-width signed products
  assign prod_dx_ylo = dir_x * off_y_lo;
  assign prod_dx_yhi = dir_x * off_y_hi;
  assign prod_dy_xlo = dir_y * off_x_lo;
  assign prod_dy_xhi = dir_y * off_x_hi;

endmodule

/* hw/rtl/srect_decide.sv */
// ---------------------------------------------------------------------------
// srect_decide: cross-product signs and hit decision
// Compares the product pairs to get the side of the segment line each
// corner lies on, then combines proper edge crossings, corners on the
// segment and endpoints inside the rectangle.
// ---------------------------------------------------------------------------
module srect_decide #(
  parameter int COORD_WIDTH = 16
) (
  input  logic signed [2*COORD_WIDTH+1:0] prod_dx_ylo,
  input  logic signed [2*COORD_WIDTH+1:0] prod_dx_yhi,
  input  logic signed [2*COORD_WIDTH+1:0] prod_dy_xlo,
  input  logic signed [2*COORD_WIDTH+1:0] prod_dy_xhi,
  input  srect_pkg::srect_flags_t         flags,
  output logic                            hit
);

  logic [srect_pkg::NUM_CORNERS-1:0] pos, neg, zero;
  logic [srect_pkg::NUM_EDGES-1:0]   cross_edge;
  logic                              corner_on_seg;

  // Side of the segment line for each corner
  always_comb begin
    pos[srect_pkg::CORNER_TL]  = prod_dx_yhi > prod_dy_xlo;
    neg[srect_pkg::CORNER_TL]  = prod_dx_yhi < prod_dy_xlo;
    pos[srect_pkg::CORNER_TR]  = prod_dx_yhi > prod_dy_xhi;
    neg[srect_pkg::CORNER_TR]  = prod_dx_yhi < prod_dy_xhi;
    pos[srect_pkg::CORNER_BL]  = prod_dx_ylo > prod_dy_xlo;
    neg[srect_pkg::CORNER_BL]  = prod_dx_ylo < prod_dy_xlo;
    pos[srect_pkg::CORNER_BR]  = prod_dx_ylo > prod_dy_xhi;
    neg[srect_pkg::CORNER_BR]  = prod_dx_ylo < prod_dy_xhi;
    zero = ~(pos | neg);
  end

  // Proper crossing: edge corners on opposite sides and segment straddling
  always_comb begin
    cross_edge[srect_pkg::EDGE_TOP] = flags.edge_straddle[srect_pkg::EDGE_TOP] &&
      ((pos[srect_pkg::CORNER_TL] && neg[srect_pkg::CORNER_TR]) ||
       (neg[srect_pkg::CORNER_TL] && pos[srect_pkg::CORNER_TR]));
    cross_edge[srect_pkg::EDGE_LEFT] = flags.edge_straddle[srect_pkg::EDGE_LEFT] &&
      ((pos[srect_pkg::CORNER_TL] && neg[srect_pkg::CORNER_BL]) ||
       (neg[srect_pkg::CORNER_TL] && pos[srect_pkg::CORNER_BL]));
    cross_edge[srect_pkg::EDGE_BOTTOM] = flags.edge_straddle[srect_pkg::EDGE_BOTTOM] &&
      ((pos[srect_pkg::CORNER_BR] && neg[srect_pkg::CORNER_BL]) ||
       (neg[srect_pkg::CORNER_BR] && pos[srect_pkg::CORNER_BL]));
    cross_edge[srect_pkg::EDGE_RIGHT] = flags.edge_straddle[srect_pkg::EDGE_RIGHT] &&
      ((pos[srect_pkg::CORNER_BR] && neg[srect_pkg::CORNER_TR]) ||
       (neg[srect_pkg::CORNER_BR] && pos[srect_pkg::CORNER_TR]));
  end

  // Corner on the segment: collinear and within its bounding box
  assign corner_on_seg = |(zero & flags.corner_in_box);

  assign hit = flags.point_inside || corner_on_seg || (|cross_edge);

endmodule

/* hw/rtl/segment_rect_intersect_top.sv */
// ---------------------------------------------------------------------------
// segment_rect_intersect_top: segment versus axis-aligned rectangle hit test
// Throughput: one request per cycle while the receiver does not stall; a request
// passes through four register stages (input, prepare, multiply, result) that
// each advance whenever the stage after them can take data, then shows its hit.
// Reset: rst clears all stage valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
module segment_rect_intersect_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] corner_one_x,
  input  logic signed [COORD_WIDTH-1:0] corner_one_y,
  input  logic signed [COORD_WIDTH-1:0] corner_two_x,
  input  logic signed [COORD_WIDTH-1:0] corner_two_y,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;

  // Input stage
  logic                          in_full;
  logic signed [COORD_WIDTH-1:0] c1x, c1y, c2x, c2y, s0x, s0y, s1x, s1y;

  // Prepare stage
  logic                          prep_full;
  logic signed [DW-1:0]          dir_x, dir_y, off_x_lo, off_x_hi, off_y_lo, off_y_hi;
  logic signed [DW-1:0]          dir_x_next, dir_y_next;
  logic signed [DW-1:0]          off_x_lo_next, off_x_hi_next, off_y_lo_next, off_y_hi_next;
  srect_pkg::srect_flags_t       prep_flags, prep_flags_next;

  // Multiply stage
  logic                          mul_full;
  logic signed [PW-1:0]          prod_dx_ylo, prod_dx_yhi, prod_dy_xlo, prod_dy_xhi;
  logic signed [PW-1:0]          prod_dx_ylo_next, prod_dx_yhi_next;
  logic signed [PW-1:0]          prod_dy_xlo_next, prod_dy_xhi_next;
  srect_pkg::srect_flags_t       mul_flags;

  // Result stage
  logic                          out_full;
  logic                          hit_next;
  logic                          result_hit;

  logic out_free, mul_free, prep_free, in_free;

  // Each stage may load when it is empty or its content moves on
  always_comb begin
    out_free  = !out_full || !out_stall;
    mul_free  = !mul_full || out_free;
    prep_free = !prep_full || mul_free;
    in_free   = !in_full || prep_free;
  end

  assign in_stall  = !in_free;
  assign out_valid = out_full;
  assign hit       = result_hit;

  // Hold stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      prep_full <= 1'b0;
      mul_full  <= 1'b0;
      out_full  <= 1'b0;
    end else begin
      if (in_free)   in_full   <= in_valid;
      if (prep_free) prep_full <= in_full;
      if (mul_free)  mul_full  <= prep_full;
      if (out_free)  out_full  <= mul_full;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_valid && in_free) begin
      c1x <= corner_one_x;
      c1y <= corner_one_y;
      c2x <= corner_two_x;
      c2y <= corner_two_y;
      s0x <= seg_start_x;
      s0y <= seg_start_y;
      s1x <= seg_end_x;
      s1y <= seg_end_y;
    end
  end

  srect_prep #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prep (
    .corner_one_x (c1x),
    .corner_one_y (c1y),
    .corner_two_x (c2x),
    .corner_two_y (c2y),
    .seg_start_x  (s0x),
    .seg_start_y  (s0y),
    .seg_end_x    (s1x),
    .seg_end_y    (s1y),
    .dir_x        (dir_x_next),
    .dir_y        (dir_y_next),
    .off_x_lo     (off_x_lo_next),
    .off_x_hi     (off_x_hi_next),
    .off_y_lo     (off_y_lo_next),
    .off_y_hi     (off_y_hi_next),
    .flags        (prep_flags_next)
  );

  // Advance into the prepare stage
  always_ff @(posedge clk) begin
    if (in_full && prep_free) begin
      dir_x      <= dir_x_next;
      dir_y      <= dir_y_next;
      off_x_lo   <= off_x_lo_next;
      off_x_hi   <= off_x_hi_next;
      off_y_lo   <= off_y_lo_next;
      off_y_hi   <= off_y_hi_next;
      prep_flags <= prep_flags_next;
    end
  end

  srect_mul #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mul (
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .off_x_lo    (off_x_lo),
    .off_x_hi    (off_x_hi),
    .off_y_lo    (off_y_lo),
    .off_y_hi    (off_y_hi),
    .prod_dx_ylo (prod_dx_ylo_next),
    .prod_dx_yhi (prod_dx_yhi_next),
    .prod_dy_xlo (prod_dy_xlo_next),
    .prod_dy_xhi (prod_dy_xhi_next)
  );

  // Advance into the multiply stage
  always_ff @(posedge clk) begin
    if (prep_full && mul_free) begin
      prod_dx_ylo <= prod_dx_ylo_next;
      prod_dx_yhi <= prod_dx_yhi_next;
      prod_dy_xlo <= prod_dy_xlo_next;
      prod_dy_xhi <= prod_dy_xhi_next;
      mul_flags   <= prep_flags;
    end
  end

  srect_decide #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_decide (
    .prod_dx_ylo (prod_dx_ylo),
    .prod_dx_yhi (prod_dx_yhi),
    .prod_dy_xlo (prod_dy_xlo),
    .prod_dy_xhi (prod_dy_xhi),
    .flags       (mul_flags),
    .hit         (hit_next)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (mul_full && out_free) begin
      result_hit <= hit_next;
    end
  end

endmodule

/* dv/segment_rect_intersect_top_test.sv */
// ----------------------------------------------------------------------------
// segment_rect_intersect_top_test: self-checking bench for the hit test
// Sends rectangle/segment requests through the valid/stall input channel and
// predicts each hit with exact 64-bit geometry. Every accepted result is
// compared in order against that prediction. Directed corner cases come first,
// then a draining pause, then random requests under four idling mixes.
// ----------------------------------------------------------------------------
module segment_rect_intersect_top_test;

  localparam int CW         = 16;
  localparam int COORD_MIN  = -32768;
  localparam int COORD_MAX  = 32767;
  localparam int PHASE_SIZE = 215;
  localparam int QUIET_MAX  = 2000;
  localparam int DRAIN_GAP  = 8;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t corner_one_x;
    coord_t corner_one_y;
    coord_t corner_two_x;
    coord_t corner_two_y;
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_end_x;
    coord_t seg_end_y;
  } query_t;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  logic   clk          = 1'b0;
  logic   rst          = 1'b1;
  logic   in_valid     = 1'b0;
  logic   in_stall;
  coord_t corner_one_x = '0;
  coord_t corner_one_y = '0;
  coord_t corner_two_x = '0;
  coord_t corner_two_y = '0;
  coord_t seg_start_x  = '0;
  coord_t seg_start_y  = '0;
  coord_t seg_end_x    = '0;
  coord_t seg_end_y    = '0;
  logic   out_valid;
  logic   out_stall    = 1'b0;
  logic   hit;

  logic expected_hits[$];
  int   mismatch_count = 0;
  int   quiet_cycles   = 0;
  int   send_idle_pct  = 0;
  int   stall_pct      = 0;

  segment_rect_intersect_top #(
    .COORD_WIDTH(CW)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .corner_one_x(corner_one_x),
    .corner_one_y(corner_one_y),
    .corner_two_x(corner_two_x),
    .corner_two_y(corner_two_y),
    .seg_start_x (seg_start_x),
    .seg_start_y (seg_start_y),
    .seg_end_x   (seg_end_x),
    .seg_end_y   (seg_end_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sign of (b-o) x (c-o)
  function automatic int turn_sign(point_t o, point_t b, point_t c);
    longint lhs;
    longint rhs;
    lhs = (b.x - o.x) * (c.y - o.y);
    rhs = (c.x - o.x) * (b.y - o.y);
    return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
  endfunction

  // True when (b-o) . (c-o) <= 0, i.e. o lies between b and c if collinear
  function automatic bit dot_nonpos(point_t o, point_t b, point_t c);
    return (b.x - o.x) * (c.x - o.x) + (b.y - o.y) * (c.y - o.y) <= 0;
  endfunction

  function automatic bit segments_touch(point_t a0, point_t a1, point_t b0, point_t b1);
    int d1;
    int d2;
    int d3;
    int d4;
    d1 = turn_sign(a0, a1, b0);
    d2 = turn_sign(a0, a1, b1);
    d3 = turn_sign(b0, b1, a0);
    d4 = turn_sign(b0, b1, a1);
    if (d1 * d2 < 0 && d3 * d4 < 0) return 1'b1;
    if (d1 == 0 && dot_nonpos(b0, a0, a1)) return 1'b1;
    if (d2 == 0 && dot_nonpos(b1, a0, a1)) return 1'b1;
    if (d3 == 0 && dot_nonpos(a0, b0, b1)) return 1'b1;
    if (d4 == 0 && dot_nonpos(a1, b0, b1)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit in_box(point_t p, longint xl, longint xh, longint yl, longint yh);
    return p.x >= xl && p.x <= xh && p.y >= yl && p.y <= yh;
  endfunction

  // Expected hit for one request: sort the corners, then endpoint and edge tests
  function automatic logic predict_hit(query_t q);
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint xl;
    longint xh;
    longint yl;
    longint yh;
    point_t s0;
    point_t s1;
    point_t tl;
    point_t tr;
    point_t bl;
    point_t br;
    ax = q.corner_one_x;
    ay = q.corner_one_y;
    bx = q.corner_two_x;
    by = q.corner_two_y;
    s0.x = q.seg_start_x;
    s0.y = q.seg_start_y;
    s1.x = q.seg_end_x;
    s1.y = q.seg_end_y;
    xl = (ax < bx) ? ax : bx;
    xh = (ax < bx) ? bx : ax;
    yl = (ay < by) ? ay : by;
    yh = (ay < by) ? by : ay;
    tl = '{xl, yh};
    tr = '{xh, yh};
    bl = '{xl, yl};
    br = '{xh, yl};
    return in_box(s0, xl, xh, yl, yh) || in_box(s1, xl, xh, yl, yh)
        || segments_touch(s0, s1, tl, tr) || segments_touch(s0, s1, tl, bl)
        || segments_touch(s0, s1, br, bl) || segments_touch(s0, s1, br, tr);
  endfunction

  // Build a request from plain integer coordinates
  function automatic query_t make_query(int c1x, int c1y, int c2x, int c2y,
                                        int s0x, int s0y, int s1x, int s1y);
    query_t q;
    q.corner_one_x = coord_t'(c1x);
    q.corner_one_y = coord_t'(c1y);
    q.corner_two_x = coord_t'(c2x);
    q.corner_two_y = coord_t'(c2y);
    q.seg_start_x  = coord_t'(s0x);
    q.seg_start_y  = coord_t'(s0y);
    q.seg_end_x    = coord_t'(s1x);
    q.seg_end_y    = coord_t'(s1y);
    return q;
  endfunction

  // Coordinate on, just beside, between or far from two rectangle edges
  function automatic coord_t near_edges(coord_t lo_edge, coord_t hi_edge);
    case ($urandom_range(5))
      0: return lo_edge;
      1: return hi_edge;
      2: return lo_edge - coord_t'($urandom_range(2)) + coord_t'(1);
      3: return hi_edge + coord_t'($urandom_range(2)) - coord_t'(1);
      4: return lo_edge + coord_t'($urandom_range(40)) - coord_t'(20);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(4))
      0: return coord_t'(COORD_MIN);
      1: return coord_t'(COORD_MAX);
      2: return coord_t'(0);
      3: return coord_t'(-1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mix of full-range, small-grid, edge-hugging and extreme requests
  function automatic query_t random_query();
    query_t q;
    int     kind;
    kind = $urandom_range(9);
    q.corner_one_x = coord_t'($urandom);
    q.corner_one_y = coord_t'($urandom);
    q.corner_two_x = coord_t'($urandom);
    q.corner_two_y = coord_t'($urandom);
    q.seg_start_x  = coord_t'($urandom);
    q.seg_start_y  = coord_t'($urandom);
    q.seg_end_x    = coord_t'($urandom);
    q.seg_end_y    = coord_t'($urandom);
    if (kind >= 2 && kind < 5) begin
      q.corner_one_x = coord_t'($urandom_range(16)) - coord_t'(8);
      q.corner_one_y = coord_t'($urandom_range(16)) - coord_t'(8);
      q.corner_two_x = coord_t'($urandom_range(16)) - coord_t'(8);
      q.corner_two_y = coord_t'($urandom_range(16)) - coord_t'(8);
      q.seg_start_x  = coord_t'($urandom_range(16)) - coord_t'(8);
      q.seg_start_y  = coord_t'($urandom_range(16)) - coord_t'(8);
      q.seg_end_x    = coord_t'($urandom_range(16)) - coord_t'(8);
      q.seg_end_y    = coord_t'($urandom_range(16)) - coord_t'(8);
    end else if (kind >= 5 && kind < 9) begin
      q.corner_two_x = q.corner_one_x + coord_t'($urandom_range(40)) - coord_t'(20);
      q.corner_two_y = q.corner_one_y + coord_t'($urandom_range(40)) - coord_t'(20);
      if ($urandom_range(7) == 0) q.corner_two_x = q.corner_one_x;
      if ($urandom_range(7) == 0) q.corner_two_y = q.corner_one_y;
      q.seg_start_x = near_edges(q.corner_one_x, q.corner_two_x);
      q.seg_start_y = near_edges(q.corner_one_y, q.corner_two_y);
      q.seg_end_x   = near_edges(q.corner_one_x, q.corner_two_x);
      q.seg_end_y   = near_edges(q.corner_one_y, q.corner_two_y);
      if ($urandom_range(9) == 0) begin
        q.seg_end_x = q.seg_start_x;
        q.seg_end_y = q.seg_start_y;
      end
    end else if (kind == 9) begin
      q.corner_one_x = extreme_coord();
      q.corner_one_y = extreme_coord();
      q.corner_two_x = extreme_coord();
      q.corner_two_y = extreme_coord();
      q.seg_start_x  = extreme_coord();
      q.seg_start_y  = extreme_coord();
      q.seg_end_x    = extreme_coord();
      q.seg_end_y    = extreme_coord();
    end
    return q;
  endfunction

  // Offer one request, idling first at the current rate, and hold it until taken
  task automatic send_request(input query_t q);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    corner_one_x <= q.corner_one_x;
    corner_one_y <= q.corner_one_y;
    corner_two_x <= q.corner_two_x;
    corner_two_y <= q.corner_two_y;
    seg_start_x  <= q.seg_start_x;
    seg_start_y  <= q.seg_start_y;
    seg_end_x    <= q.seg_end_x;
    seg_end_y    <= q.seg_end_y;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every outstanding hit has been returned
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_hits.size() != 0);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct     = 0;
    // one endpoint inside, corners given in three orders
    send_request(make_query(0, 0, 10, 10, 5, 5, 20, 20));
    send_request(make_query(10, 10, 0, 0, 5, 5, 20, 20));
    send_request(make_query(10, 0, 0, 10, 20, 20, 5, 5));
    // crossing straight through, both ends outside
    send_request(make_query(0, 0, 10, 10, -5, 5, 15, 5));
    // clear miss
    send_request(make_query(0, 0, 10, 10, 20, 20, 30, -5));
    // passing exactly through a corner
    send_request(make_query(0, 0, 10, 10, 5, 15, 15, 5));
    // diagonal just missing a corner
    send_request(make_query(0, 0, 10, 10, 5, 16, 16, 5));
    // collinear with top edge, overlapping then disjoint
    send_request(make_query(0, 0, 10, 10, -5, 10, 15, 10));
    send_request(make_query(0, 0, 10, 10, 12, 10, 20, 10));
    // collinear with left edge extended, beyond the box
    send_request(make_query(0, 0, 10, 10, 0, 12, 0, 20));
    // ending exactly on an edge from outside
    send_request(make_query(0, 0, 10, 10, -5, 5, 0, 5));
    // vertical line one pixel left of the box
    send_request(make_query(0, 0, 10, 10, -1, -5, -1, 15));
    // rectangle collapsed to a point, hit and miss
    send_request(make_query(3, 3, 3, 3, 0, 0, 6, 6));
    send_request(make_query(3, 3, 3, 3, 0, 0, 6, 7));
    // rectangle collapsed to a line, crossed
    send_request(make_query(0, 5, 10, 5, 5, 0, 5, 10));
    // segment collapsed to a point: inside, outside, on the boundary
    send_request(make_query(0, 0, 10, 10, 4, 4, 4, 4));
    send_request(make_query(0, 0, 10, 10, 11, 4, 11, 4));
    send_request(make_query(0, 0, 10, 10, 10, 4, 10, 4));
    // full-range box and full-range segments
    send_request(make_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    send_request(make_query(-1, -1, 1, 1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
    send_request(make_query(COORD_MIN, COORD_MAX, -32767, 32766,
                            COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX));
    send_request(make_query(0, 0, -1, 0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    send_request(make_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_request(make_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 0;
    stall_pct     = 47;
    repeat (10) send_request(random_query());
    wait_for_drain();
    repeat (10) send_request(random_query());
  endtask

  task automatic test_random_phases();
    int idle_mix[4];
    int stall_mix[4];
    idle_mix  = '{0, 47, 0, 36};
    stall_mix = '{0, 0, 47, 36};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mix[p];
      stall_pct     = stall_mix[p];
      repeat (PHASE_SIZE) send_request(random_query());
    end
  endtask

  // Receiver stall at the current rate
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Predict on each accepted request, compare each accepted hit, guard progress
  always @(posedge clk) begin : port_watch
    query_t seen;
    logic   want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen.corner_one_x = corner_one_x;
        seen.corner_one_y = corner_one_y;
        seen.corner_two_x = corner_two_x;
        seen.corner_two_y = corner_two_y;
        seen.seg_start_x  = seg_start_x;
        seen.seg_start_y  = seg_start_y;
        seen.seg_end_x    = seg_end_x;
        seen.seg_end_y    = seg_end_y;
        expected_hits.push_back(predict_hit(seen));
      end
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $error("hit: expected no result, got %0b", hit);
          mismatch_count++;
        end else begin
          want = expected_hits.pop_front();
          if (hit !== want) begin
            $error("hit: expected %0b, got %0b", want, hit);
            mismatch_count++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("segment_rect_intersect_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_drain_pause();
    test_random_phases();
    wait_for_drain();
    repeat (DRAIN_GAP) @(posedge clk);
    if (mismatch_count == 0 && expected_hits.size() == 0) begin
      $display("segment_rect_intersect_top verification clean");
    end else begin
      $display("segment_rect_intersect_top verification failed");
    end
    $finish;
  end

endmodule
